[src/tbp_pkg.sv]
// Shared types, constants and helpers for the tournament branch predictor.
// No dependencies; every other file imports this package.
package tbp_pkg;

	localparam int ADDR_W = 48;
	localparam int CNT_W  = 32;
	localparam int CTR_W  = 2;

	// Reset value of every counter: strongly taken, or strongly gshare for the chooser.
	localparam logic [CTR_W-1:0] CTR_INIT = 2'd3;
	localparam logic [CTR_W-1:0] CTR_MAX  = 2'd3;
	localparam logic [CTR_W-1:0] CTR_MIN  = 2'd0;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CTR_W-1:0] ctr_t;

	typedef struct packed {
		logic predicted_taken;
		logic correct;
		logic chose_gshare;
		cnt_t correct_count;
		cnt_t branch_count;
	} result_t;

	// Upper half of a 2-bit counter means taken (or gshare for the chooser).
	function automatic logic ctr_high(input ctr_t c);
		return c[CTR_W-1];
	endfunction

	// Saturating step of a 2-bit counter.
	function automatic ctr_t sat_move(input ctr_t c, input logic up);
		ctr_t r;
		if (up) begin
			r = (c == CTR_MAX) ? CTR_MAX : ctr_t'(c + ctr_t'(1));
		end else begin
			r = (c == CTR_MIN) ? CTR_MIN : ctr_t'(c - ctr_t'(1));
		end
		return r;
	endfunction

endpackage

[src/tbp_branch_if.sv]
// Input channel of the predictor: one resolved branch per transfer.
// Depends on tbp_pkg for the address width.
interface tbp_branch_if import tbp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] branch_addr;
	logic              taken;

	modport source (output valid, output branch_addr, output taken, input ready);
	modport sink   (input valid, input branch_addr, input taken, output ready);
endinterface

[src/tbp_result_if.sv]
// Output channel of the predictor: one prediction result per transfer.
// Depends on tbp_pkg for the count width.
interface tbp_result_if import tbp_pkg::*; ();
	logic valid;
	logic ready;
	logic predicted_taken;
	logic correct;
	logic chose_gshare;
	cnt_t correct_count;
	cnt_t branch_count;

	modport source (output valid, output predicted_taken, output correct, output chose_gshare,
		output correct_count, output branch_count, input ready);
	modport sink   (input valid, input predicted_taken, input correct, input chose_gshare,
		input correct_count, input branch_count, output ready);
endinterface

[src/tournament_branch_predictor_core.sv]
// Tournament branch predictor (bimodal + gshare with a per-address chooser).
// An accepted branch is registered into stage 1, where its result is formed and written
// into the result buffer; it can transfer from there once it is at the buffer's head.
// Throughput: one branch per cycle while the result buffer has room, set by the single
// read and write port of each table. Reset: arst_n clears control state, then a clearing
// pass writes strongly taken / strongly gshare into every table entry with br.ready low.
// TABLE_ENTRIES must be a power of two. Depends on tbp_pkg, tbp_branch_if, tbp_result_if.
module tournament_branch_predictor_core import tbp_pkg::*; #(
	parameter int TABLE_ENTRIES = 2048
) (
	input  logic             clk,
	input  logic             arst_n,
	tbp_branch_if.sink       br,
	tbp_result_if.source     res
);

	localparam int IDX_W      = $clog2(TABLE_ENTRIES);
	localparam int FIFO_DEPTH = 3;
	localparam int PTR_W      = 2;
	localparam int OCC_W      = 2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [PTR_W-1:0] ptr_t;

	// Chooser and bimodal share an index, so they share one memory word.
	typedef struct packed {
		ctr_t chooser;
		ctr_t bimodal;
	} bc_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

	state_t state_q;
	idx_t   clr_idx_q;
	idx_t   hist_q;
	cnt_t   hits_q;
	cnt_t   seen_q;

	// ---------------------------------------------------------------
	// Stage 0: accept a branch, form indices, issue memory reads.
	// ---------------------------------------------------------------
	logic br_xfer;
	idx_t bi_s0;
	idx_t gi_s0;

	assign br_xfer = br.valid && br.ready;
	assign bi_s0   = br.branch_addr[IDX_W-1:0];
	assign gi_s0   = bi_s0 ^ hist_q;

	// Stage 1 registers.
	logic s1_vld;
	idx_t bi_s1;
	idx_t gi_s1;
	logic taken_s1;

	// Memories and their registered read data.
	bc_t  bc_mem [TABLE_ENTRIES];
	ctr_t gs_mem [TABLE_ENTRIES];
	bc_t  bc_rd_s1;
	ctr_t gs_rd_s1;

	// Write ports.
	logic mem_we;
	idx_t bc_wa;
	idx_t gs_wa;
	bc_t  bc_wd;
	ctr_t gs_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bc_mem[bc_wa] <= bc_wd;
		end
		if (br_xfer) begin
			bc_rd_s1 <= bc_mem[bi_s0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			gs_mem[gs_wa] <= gs_wd;
		end
		if (br_xfer) begin
			gs_rd_s1 <= gs_mem[gi_s0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld <= 1'b0;
		end else begin
			s1_vld <= br_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (br_xfer) begin
			bi_s1    <= bi_s0;
			gi_s1    <= gi_s0;
			taken_s1 <= br.taken;
		end
	end

	// History only depends on the outcome, so advance it at the input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (br_xfer) begin
			hist_q <= {hist_q[IDX_W-2:0], br.taken};
		end
	end

	// ---------------------------------------------------------------
	// Forwarding: a write at the same edge as this item's read is not
	// seen by the read, so the last write is registered and forwarded.
	// ---------------------------------------------------------------
	logic byp_vld_q;
	idx_t byp_bi_q;
	idx_t byp_gi_q;
	bc_t  byp_bc_q;
	ctr_t byp_gs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_vld_q <= 1'b0;
		end else begin
			byp_vld_q <= s1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_vld) begin
			byp_bi_q <= bi_s1;
			byp_gi_q <= gi_s1;
			byp_bc_q <= bc_wd;
			byp_gs_q <= gs_wd;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: predict, train, write back, bump the counts.
	// ---------------------------------------------------------------
	bc_t  bc_cur;
	ctr_t gs_cur;
	logic bpred;
	logic gpred;
	logic use_g;
	logic pred;
	logic ok;
	ctr_t chooser_nx;
	cnt_t seen_nx;
	cnt_t hits_nx;

	always_comb begin
		bc_cur = (byp_vld_q && byp_bi_q == bi_s1) ? byp_bc_q : bc_rd_s1;
		gs_cur = (byp_vld_q && byp_gi_q == gi_s1) ? byp_gs_q : gs_rd_s1;
		bpred  = ctr_high(bc_cur.bimodal);
		gpred  = ctr_high(gs_cur);
		use_g  = ctr_high(bc_cur.chooser);
		pred   = use_g ? gpred : bpred;
		ok     = (pred == taken_s1);

		// Move the chooser only when the two predictors disagree.
		chooser_nx = (bpred != gpred) ? sat_move(bc_cur.chooser, gpred == taken_s1)
			: bc_cur.chooser;

		seen_nx = (&seen_q) ? seen_q : cnt_t'(seen_q + cnt_t'(1));
		hits_nx = (ok && !(&hits_q)) ? cnt_t'(hits_q + cnt_t'(1)) : hits_q;
	end

	// Write mux: the clearing pass or the stage-1 writeback.
	always_comb begin
		mem_we = 1'b0;
		bc_wa  = bi_s1;
		gs_wa  = gi_s1;
		bc_wd  = '{chooser: chooser_nx, bimodal: sat_move(bc_cur.bimodal, taken_s1)};
		gs_wd  = sat_move(gs_cur, taken_s1);
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				bc_wa  = clr_idx_q;
				gs_wa  = clr_idx_q;
				bc_wd  = '{chooser: CTR_INIT, bimodal: CTR_INIT};
				gs_wd  = CTR_INIT;
			end
			ST_RUN: begin
				mem_we = s1_vld;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
			seen_q <= '0;
		end else if (s1_vld) begin
			hits_q <= hits_nx;
			seen_q <= seen_nx;
		end
	end

	// Clearing pass: sweep every entry once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= idx_t'(clr_idx_q + idx_t'(1));
					if (&clr_idx_q) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Result buffer: stage 1 never stalls, so the input side reserves
	// room here for every item in flight before taking a new one.
	// ---------------------------------------------------------------
	result_t fifo_q [FIFO_DEPTH];
	ptr_t    wr_ptr_q;
	ptr_t    rd_ptr_q;
	logic [OCC_W-1:0] occ_q;
	logic    push;
	logic    pop;
	result_t res_s1;

	assign push = s1_vld;
	assign pop  = res.valid && res.ready;

	assign res_s1 = '{predicted_taken: pred, correct: ok, chose_gshare: use_g,
		correct_count: hits_nx, branch_count: seen_nx};

	function automatic ptr_t ptr_inc(input ptr_t p);
		return (p == ptr_t'(FIFO_DEPTH - 1)) ? '0 : ptr_t'(p + ptr_t'(1));
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			priority if (push && !pop) begin
				occ_q <= OCC_W'(occ_q + OCC_W'(1));
			end else if (pop && !push) begin
				occ_q <= OCC_W'(occ_q - OCC_W'(1));
			end else begin
				occ_q <= occ_q;
			end
		end
	end

	// Take a branch only when the buffer has room for it and the one in stage 1.
	assign br.ready = (state_q == ST_RUN)
		&& ((3'(occ_q) + 3'(s1_vld)) < 3'(FIFO_DEPTH));

	assign res.valid           = (occ_q != '0);
	assign res.predicted_taken = fifo_q[rd_ptr_q].predicted_taken;
	assign res.correct         = fifo_q[rd_ptr_q].correct;
	assign res.chose_gshare    = fifo_q[rd_ptr_q].chose_gshare;
	assign res.correct_count   = fifo_q[rd_ptr_q].correct_count;
	assign res.branch_count    = fifo_q[rd_ptr_q].branch_count;

endmodule
